// ===== rtl/sdts_pkg.sv =====
// shared types, constants and defaults for the span depth-test shader
`timescale 1ns / 1ps
package sdts_pkg;

   localparam int DEF_SCREEN_WIDTH  = 64;
   localparam int DEF_SCREEN_HEIGHT = 64;
   localparam logic [23:0] BASE_COLOR_RESET = 24'hcccccc;

   // restoring divide, one quotient bit per cycle
   localparam int DIV_STEPS = 52;
   localparam int DIV_CW    = 6;
   localparam int ACC_W     = 54;
   localparam int XW        = 18;

   typedef struct packed {
      logic signed [15:0] x_start;
      logic signed [15:0] x_end;
      logic signed [11:0] row;
      logic [15:0]        bright_start;
      logic [15:0]        bright_end;
      logic [31:0]        depth_start;
      logic [31:0]        depth_end;
   } req_item_type;

   typedef struct packed {
      logic [5:0]  pixel_x;
      logic [5:0]  pixel_y;
      logic        written;
      logic [23:0] pixel_color;
      logic [31:0] pixel_depth;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic div_step;
      logic col_step;
      logic mem_read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic skip;
      logic div_last;
      logic span_done;
      logic on_screen;
      logic out_free;
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_DIV   = 5'b00100,
      S_READ  = 5'b01000,
      S_TEST  = 5'b10000
   } state_type;

endpackage

// ===== rtl/sdts_req_if.sv =====
// span request channel
`timescale 1ns / 1ps
interface sdts_req_if;
   logic                  valid;
   logic                  ready;
   sdts_pkg::req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/sdts_rsp_if.sv =====
// pixel result channel
`timescale 1ns / 1ps
interface sdts_rsp_if;
   logic                  valid;
   logic                  ready;
   sdts_pkg::rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/span_depth_test_shader.sv =====
// span depth-test shader top level
// Takes one span at a time. After reset the depth store is cleared, one
// word per cycle, over all SCREEN_WIDTH*SCREEN_HEIGHT words before the
// first span is accepted. A span with equal ends or an off-screen row is
// taken and dropped without a walk. Otherwise it is loaded, the slope
// dividers run (one quotient bit per cycle), then each off-screen column
// is stepped over and each on-screen column gets a depth store read, then
// test and write, and a last step finishes the span. A finished pixel
// waits in the output register while the walk goes on; stalls on the
// result channel hold the walk at the next pixel.
`timescale 1ns / 1ps
module span_depth_test_shader #(
   parameter int SCREEN_WIDTH  = sdts_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = sdts_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   sdts_req_if.sink    req_if,
   sdts_rsp_if.source  rsp_if,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);

   sdts_pkg::cmd_type    cmd;
   sdts_pkg::status_type st;

   sdts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .st        (st)
   );

   sdts_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_item         (req_if.item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_if.valid),
      .rsp_item         (rsp_if.item),
      .rsp_ready        (rsp_if.ready)
   );

endmodule

// ===== rtl/sdts_ctrl.sv =====
// sequencing state machine for clear, divide and column steps
`timescale 1ns / 1ps
module sdts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output sdts_pkg::cmd_type      cmd,
   input  sdts_pkg::status_type   st
);

   sdts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdts_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == sdts_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         sdts_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) state_in = sdts_pkg::S_IDLE;
         end
         sdts_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!st.skip) state_in = sdts_pkg::S_DIV;
            end
         end
         sdts_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) state_in = sdts_pkg::S_READ;
         end
         sdts_pkg::S_READ: begin
            if (st.span_done) begin
               state_in = sdts_pkg::S_IDLE;
            end else if (st.on_screen) begin
               cmd.mem_read = 1'b1;
               state_in     = sdts_pkg::S_TEST;
            end else begin
               cmd.col_step = 1'b1;
            end
         end
         sdts_pkg::S_TEST: begin
            if (st.out_free) begin
               cmd.commit = 1'b1;
               state_in   = sdts_pkg::S_READ;
            end
         end
         default: state_in = sdts_pkg::S_IDLE;
      endcase
   end

endmodule

// ===== rtl/sdts_datapath.sv =====
// span setup, slope dividers, interpolators, depth store and result register
`timescale 1ns / 1ps
module sdts_datapath #(
   parameter int SCREEN_WIDTH  = sdts_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = sdts_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sdts_pkg::cmd_type      cmd,
   output sdts_pkg::status_type   st,
   input  sdts_pkg::req_item_type req_item,
   input  logic                   csr_write_enable,
   input  logic [23:0]            csr_write_data,
   output logic                   rsp_valid,
   output sdts_pkg::rsp_item_type rsp_item,
   input  logic                   rsp_ready
);

   localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(SCREEN_WIDTH);
   localparam int YW    = $clog2(SCREEN_HEIGHT);
   localparam int XW    = sdts_pkg::XW;
   localparam int AccW  = sdts_pkg::ACC_W;

   logic [23:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= sdts_pkg::BASE_COLOR_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   // span setup
   logic               swap;
   logic signed [15:0] xl, xh;
   logic [15:0]        hl, hh;
   logic [31:0]        zl, zh;
   logic signed [32:0] dz;
   logic signed [16:0] dh;
   logic [31:0]        dz_mag;
   logic [15:0]        dh_mag;

   always_comb begin
      swap   = req_item.x_start > req_item.x_end;
      xl     = swap ? req_item.x_end : req_item.x_start;
      xh     = swap ? req_item.x_start : req_item.x_end;
      hl     = swap ? req_item.bright_end : req_item.bright_start;
      hh     = swap ? req_item.bright_start : req_item.bright_end;
      zl     = swap ? req_item.depth_end : req_item.depth_start;
      zh     = swap ? req_item.depth_start : req_item.depth_end;
      dz     = $signed({1'b0, zh}) - $signed({1'b0, zl});
      dh     = $signed({1'b0, hh}) - $signed({1'b0, hl});
      dz_mag = dz[32] ? 32'(-dz) : dz[31:0];
      dh_mag = dh[16] ? 16'(-dh) : dh[15:0];
   end

   assign st.skip = (req_item.x_start == req_item.x_end) || req_item.row[11] ||
                    (13'({1'b0, req_item.row}) >= 13'(SCREEN_HEIGHT));

   // dividers
   logic [15:0]                  dx_ff;
   logic [sdts_pkg::DIV_CW-1:0]  cnt_ff;
   logic [51:0]                  zn_ff, hn_ff;
   logic [15:0]                  zr_ff, hr_ff;
   logic                         zneg_ff, hneg_ff;
   logic [16:0]                  zt, ht;
   logic                         zge, hge;

   always_comb begin
      zt  = {zr_ff, zn_ff[51]};
      ht  = {hr_ff, hn_ff[51]};
      zge = zt >= {1'b0, dx_ff};
      hge = ht >= {1'b0, dx_ff};
   end

   assign st.div_last = (cnt_ff == sdts_pkg::DIV_CW'(sdts_pkg::DIV_STEPS - 1));

   logic signed [52:0] z_slope, h_slope;
   assign z_slope = zneg_ff ? -$signed({1'b0, zn_ff}) : $signed({1'b0, zn_ff});
   assign h_slope = hneg_ff ? -$signed({1'b0, hn_ff}) : $signed({1'b0, hn_ff});

   // column walk
   logic signed [XW-1:0]   x_ff, xh_ff, xn;
   logic signed [AccW-1:0] zacc_ff, hacc_ff;
   logic [11:0]            row_ff;
   logic                   step;
   logic [CW-1:0]          col;
   logic [AW-1:0]          addr;
   logic [31:0]            z_now;
   logic [15:0]            h_now;

   assign step  = cmd.col_step | cmd.commit;
   assign xn    = x_ff + XW'(16);
   assign col   = x_ff[CW+3:4];
   assign addr  = AW'(col) + AW'(row_ff[YW-1:0]) * AW'(SCREEN_WIDTH);
   assign z_now = zacc_ff[47:16];
   assign h_now = hacc_ff[31:16];

   assign st.span_done = (x_ff > xh_ff) ||
                         (!x_ff[XW-1] && (x_ff[XW-1:4] >= 14'(SCREEN_WIDTH)));
   assign st.on_screen = !x_ff[XW-1] && (x_ff[XW-1:4] < 14'(SCREEN_WIDTH));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff   <= 16'(XW'(xh) - XW'(xl));
         cnt_ff  <= '0;
         zn_ff   <= {dz_mag, 20'b0};
         hn_ff   <= {16'b0, dh_mag, 20'b0};
         zr_ff   <= '0;
         hr_ff   <= '0;
         zneg_ff <= dz[32];
         hneg_ff <= dh[16];
         x_ff    <= XW'(xl);
         xh_ff   <= XW'(xh);
         zacc_ff <= $signed(AccW'({zl, 16'b0}));
         hacc_ff <= $signed(AccW'({hl, 16'b0}));
         row_ff  <= req_item.row;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         zn_ff  <= {zn_ff[50:0], zge};
         hn_ff  <= {hn_ff[50:0], hge};
         zr_ff  <= zge ? 16'(zt - {1'b0, dx_ff}) : zt[15:0];
         hr_ff  <= hge ? 16'(ht - {1'b0, dx_ff}) : ht[15:0];
      end else if (step) begin
         x_ff    <= xn;
         zacc_ff <= zacc_ff + AccW'(z_slope);
         hacc_ff <= hacc_ff + AccW'(h_slope);
      end
   end

   // depth store with clearing pass
   logic [31:0]   mem [CELLS];
   logic [31:0]   rd_ff;
   logic [AW-1:0] clr_ff;
   logic          pass;

   assign st.clear_last = (clr_ff == AW'(CELLS - 1));
   assign pass          = z_now >= rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.commit && pass) begin
         mem[addr] <= z_now;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[addr];
      end
   end

   // shading
   logic [23:0] color;
   logic [23:0] prod [3];
   logic [8:0]  chan [3];

   always_comb begin
      for (int s = 0; s < 3; s++) begin
         prod[s]          = 24'(base_ff[8*s +: 8]) * 24'(h_now);
         chan[s]          = prod[s][23:15];
         color[8*s +: 8]  = chan[s][8] ? 8'hff : chan[s][7:0];
      end
   end

   // result register
   logic                   rsp_valid_ff;
   sdts_pkg::rsp_item_type rsp_item_ff;

   assign st.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit | (rsp_valid_ff & ~rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_item_ff.pixel_x     <= x_ff[9:4];
         rsp_item_ff.pixel_y     <= row_ff[5:0];
         rsp_item_ff.written     <= pass;
         rsp_item_ff.pixel_color <= pass ? color : 24'h0;
         rsp_item_ff.pixel_depth <= z_now;
         rsp_item_ff.last        <= (xn > xh_ff) || (xn[XW-1:4] >= 14'(SCREEN_WIDTH));
      end
   end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the span depth-test shader
`timescale 1ns / 1ps
module tb;

   localparam int SW = 64;
   localparam int SH = 64;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [23:0] csr_write_data = '0;

   sdts_req_if req_if ();
   sdts_rsp_if rsp_if ();

   span_depth_test_shader u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if.sink),
      .rsp_if           (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   logic [31:0]            zbuf [0:SW*SH-1];
   logic [23:0]            color_reg;
   sdts_pkg::rsp_item_type pixel_q [$];
   int unsigned            send_idle_pct = 0;
   int unsigned            recv_idle_pct = 0;
   int unsigned            quiet_cycles = 0;
   bit                     failed = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.item = '0;
      rsp_if.ready = 1'b0;
   end

   // channel scale: (c * b) >> 15, clamped to 255
   function automatic logic [23:0] shade_color(logic [31:0] b);
      logic [23:0] res;
      longint      v;
      res = '0;
      for (int s = 0; s < 24; s += 8) begin
         v = (longint'(color_reg[s +: 8]) * longint'(b)) >>> 15;
         if (v > 255) v = 255;
         res[s +: 8] = v[7:0];
      end
      return res;
   endfunction

   task automatic predict_span(sdts_pkg::req_item_type it);
      longint xa, xb, y, ha, hb, za, zb, t, dx, hs, zs, hacc, zacc, col;
      int unsigned n;
      int idx;
      logic [31:0] z, h;
      sdts_pkg::rsp_item_type p;
      n = 0;
      xa = it.x_start; xb = it.x_end; y = it.row;
      ha = it.bright_start; hb = it.bright_end;
      za = it.depth_start; zb = it.depth_end;
      if (xa == xb || y < 0 || y >= SH) return;
      if (xa > xb) begin
         t = xa; xa = xb; xb = t;
         t = ha; ha = hb; hb = t;
         t = za; za = zb; zb = t;
      end
      dx = xb - xa;
      hs = ((hb - ha) * 1048576) / dx;
      zs = ((zb - za) * 1048576) / dx;
      hacc = ha * 65536;
      zacc = za * 65536;
      for (longint x = xa; x <= xb; x += 16) begin
         if (x >= 0 && (x / 16) < SW) begin
            col = x / 16;
            idx = int'(col + y * SW);
            z = 32'(zacc >>> 16);
            h = 32'(hacc >>> 16);
            p = '0;
            p.pixel_x = col[5:0];
            p.pixel_y = y[5:0];
            p.pixel_depth = z;
            if (z >= zbuf[idx]) begin
               zbuf[idx] = z;
               p.written = 1'b1;
               p.pixel_color = shade_color(h);
            end
            pixel_q.push_back(p);
            n++;
         end
         hacc += hs;
         zacc += zs;
      end
      if (n > 0) pixel_q[$].last = 1'b1;
   endtask

   task automatic send_span(sdts_pkg::req_item_type it);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.item <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_span(it);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected pixel %p", $time, rsp_if.item);
               failed = 1'b1;
            end else begin
               if (rsp_if.item !== pixel_q[0]) begin
                  $display("%0t: pixel mismatch expected %p actual %p",
                           $time, pixel_q[0], rsp_if.item);
                  failed = 1'b1;
               end
               void'(pixel_q.pop_front());
            end
         end
         rsp_if.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0 || !req_if.ready) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_color(logic [23:0] c);
      csr_write_enable <= 1'b1;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      color_reg = c;
   endtask

   function automatic sdts_pkg::req_item_type make_span(int xs, int xe, int r, int bs,
                                                        int be, logic [31:0] zs,
                                                        logic [31:0] ze);
      sdts_pkg::req_item_type it;
      it.x_start = 16'(xs); it.x_end = 16'(xe); it.row = 12'(r);
      it.bright_start = 16'(bs); it.bright_end = 16'(be);
      it.depth_start = zs; it.depth_end = ze;
      return it;
   endfunction

   function automatic sdts_pkg::req_item_type rand_span();
      sdts_pkg::req_item_type it;
      it = sdts_pkg::req_item_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom});
      if ($urandom_range(9) < 8) begin
         it.row = 12'($urandom_range(SH - 1));
         it.x_start = 16'(int'($urandom_range(1100)) - 40);
         if ($urandom_range(3) == 0)
            it.x_end = 16'(int'(it.x_start) + int'($urandom_range(64)) - 32);
         else
            it.x_end = 16'(int'($urandom_range(1100)) - 40);
      end
      return it;
   endfunction

   task automatic test_directed();
      send_span(make_span(100, 100, 5, 0, 0, 32'h10000, 32'h10000));
      send_span(make_span(0, 1023, 0, 0, 65535, 0, 32'hffffffff));
      send_span(make_span(1023, 0, 1, 65535, 0, 32'hffffffff, 0));
      send_span(make_span(-32768, 32767, 63, 32768, 32768, 32'h8000, 32'h8000));
      send_span(make_span(32767, -32768, 63, 0, 65535, 32'h8000, 32'h9000));
      send_span(make_span(0, 160, -1, 100, 200, 5, 6));
      send_span(make_span(0, 160, 64, 100, 200, 5, 6));
      send_span(make_span(0, 160, -2048, 100, 200, 5, 6));
      send_span(make_span(0, 160, 2047, 100, 200, 5, 6));
      send_span(make_span(-40, 40, 2, 65535, 65535, 100, 100));
      send_span(make_span(-40, 40, 2, 65535, 65535, 99, 99));
      send_span(make_span(1000, 1100, 3, 1000, 1000, 1, 1));
      send_span(make_span(1030, 1100, 3, 1000, 1000, 1, 1));
      send_span(make_span(-100, -20, 3, 1000, 1000, 1, 1));
      send_span(make_span(7, 9, 4, 40000, 0, 0, 0));
      send_span(make_span(0, 16, 4, 0, 0, 0, 0));
      wait_drained();
   endtask

   task automatic test_colors();
      logic [23:0] palette [4] = '{24'h000000, 24'hffffff, 24'h123456, 24'hff00aa};
      foreach (palette[i]) begin
         write_color(palette[i]);
         for (int k = 0; k < 5; k++) send_span(rand_span());
         wait_drained();
      end
   endtask

   task automatic test_random(int count);
      for (int k = 0; k < count; k++) begin
         if (k % 25 == 24) begin
            wait_drained();
            write_color(24'($urandom));
         end
         send_span(rand_span());
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < SW * SH; i++) zbuf[i] = '0;
      color_reg = sdts_pkg::BASE_COLOR_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_colors();
      send_idle_pct = 33; recv_idle_pct = 77;
      test_random(65);
      send_idle_pct = 77; recv_idle_pct = 33;
      test_random(65);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(65);
      if (!failed)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
